// File: rtl/lsh_pkg.sv
package lsh_pkg;

  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int RGB_W     = 24;
  localparam int CFG_W     = 13;
  localparam int STR_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHARPEN_STRENGTH = 2'd2;

  localparam int RST_IMAGE_WIDTH      = 1024;
  localparam int RST_IMAGE_HEIGHT     = 1024;
  localparam int RST_SHARPEN_STRENGTH = 64;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // one classified item: optional result of the row above, optional bottom-row pixel
  typedef struct packed {
    logic [PIX_W-1:0] res;
    logic [PIX_W-1:0] px;
    logic             has_res;
    logic             has_px;
    logic             eof;
  } lsh_entry_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
  } lsh_q_status_t;

endpackage

// File: rtl/laplacian_sharpen_stream.sv
// path: a pixel of row r-1 leaves after the same column of row r is taken, via the stage register and the queue
// throughput: one pixel per clock while the output is ready; in the last row each pixel gives two results through
//   the single output port, so input is held back there while the queue fills
// reset: synchronous, clears position, queue and window, loads width 1024, height 1024,
//   strength 64; line stores are not cleared, the first two rows of a frame fill them
module laplacian_sharpen_stream #(
  parameter int MAX_WIDTH  = lsh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lsh_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lsh_pkg::PIX_W-1:0]     s_tdata,   // red, green, blue, alpha
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lsh_pkg::PIX_W-1:0]     m_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic                          m_tlast,   // end_of_frame
  output logic                          m_tuser,   // last_of_item
  input  logic                          cfg_we,
  input  logic [lsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsh_pkg::CFG_W-1:0]     cfg_data
);
  import lsh_pkg::*;

  logic          push, pop;
  lsh_entry_t    push_entry, head;
  lsh_q_status_t q_stat;

  lsh_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  lsh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  lsh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/lsh_front.sv
module lsh_front #(
  parameter int MAX_WIDTH  = lsh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lsh_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lsh_pkg::PIX_W-1:0]      s_tdata,
  input  logic                           cfg_we,
  input  logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsh_pkg::CFG_W-1:0]      cfg_data,
  input  lsh_pkg::lsh_q_status_t         q_stat,
  output logic                           push,
  output lsh_pkg::lsh_entry_t            push_entry
);
  import lsh_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int EWW   = (WW > CFG_W) ? WW : CFG_W;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int EHW   = (HW > CFG_W) ? HW : CFG_W;
  localparam int CRW   = Q_CNT_W + 1;

  function automatic logic [CH_W-1:0] sharpen(
    input logic [CH_W-1:0]  c,
    input logic [CH_W-1:0]  u,
    input logic [CH_W-1:0]  d,
    input logic [CH_W-1:0]  l,
    input logic [CH_W-1:0]  r,
    input logic [STR_W-1:0] g
  );
    logic signed [10:0] lap;
    logic signed [10:0] gain;
    logic signed [21:0] prod;
    logic signed [22:0] sum;
    logic [CH_W-1:0]    y;
    lap  = $signed({1'b0, c, 2'b00}) - $signed({3'b000, u}) - $signed({3'b000, d})
         - $signed({3'b000, l}) - $signed({3'b000, r});
    gain = $signed({1'b0, g});
    prod = gain * lap;
    sum  = $signed({7'b0, c, 8'h00}) + prod;
    if (sum < 0) begin
      y = '0;
    end else if (sum > 23'sd65535) begin
      y = '1;
    end else begin
      y = sum[15:8];
    end
    return y;
  endfunction

  // configuration
  logic [CFG_W-1:0] img_w;
  logic [CFG_W-1:0] img_h;
  logic [STR_W-1:0] strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w    <= CFG_W'(RST_IMAGE_WIDTH);
      img_h    <= CFG_W'(RST_IMAGE_HEIGHT);
      strength <= STR_W'(RST_SHARPEN_STRENGTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:      img_w    <= cfg_data;
        REG_IMAGE_HEIGHT:     img_h    <= cfg_data;
        REG_SHARPEN_STRENGTH: strength <= cfg_data[STR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (img_w == '0) begin
      eff_w = WW'(1);
    end else if (EWW'(img_w) > EWW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(img_w);
    end
    if (img_h == '0) begin
      eff_h = HW'(1);
    end else if (EHW'(img_h) > EHW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(img_h);
    end
  end

  // raster position
  logic [COL_W-1:0] col, col_next, c, c_plus;
  logic [ROW_W-1:0] row, row_next, r;
  logic             last_col, last_row, accept;

  // stage register between accept and compute
  logic             s_valid;
  logic [PIX_W-1:0] s_px;
  logic [COL_W-1:0] s_col;
  logic             s_has_res;
  logic             s_border;
  logic             s_last_row;
  logic             s_eof;

  assign s_tready = ({1'b0, q_stat.count} + CRW'(s_valid)) < CRW'(QUEUE_DEPTH);
  assign accept   = s_tvalid & s_tready;

  always_comb begin
    c        = (WW'(col) >= eff_w) ? '0 : col;
    r        = (HW'(row) >= eff_h) ? '0 : row;
    c_plus   = c + COL_W'(1);
    last_col = (WW'(c) + WW'(1)) == eff_w;
    last_row = (HW'(r) + HW'(1)) == eff_h;
    col_next = last_col ? '0 : c_plus;
    if (!last_col) begin
      row_next = r;
    end else if (last_row) begin
      row_next = '0;
    end else begin
      row_next = r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_px       <= s_tdata;
      s_col      <= c;
      s_has_res  <= (r != '0);
      s_border   <= (r == ROW_W'(1)) || (c == '0) || last_col;
      s_last_row <= last_row;
      s_eof      <= last_col;
    end
  end

  // line stores: previous row RGBA, row before that RGB
  logic [PIX_W-1:0] prev_mem [MAX_WIDTH];
  logic [RGB_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_ctr, rd_rgt;
  logic [RGB_W-1:0] rd_up;
  logic [PIX_W-1:0] win_left;
  logic [PIX_W-1:0] res;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ctr      <= prev_mem[c];
      rd_rgt      <= prev_mem[c_plus];
      prev_mem[c] <= s_tdata;
    end
  end

  // older row gets the previous-row pixel once it has been read out
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_up <= older_mem[c];
    end
    if (s_valid) begin
      older_mem[s_col] <= rd_ctr[RGB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left <= '0;
    end else if (s_valid) begin
      win_left <= rd_ctr;
    end
  end

  always_comb begin
    res = rd_ctr;
    if (!s_border) begin
      for (int k = 0; k < 3; k++) begin
        res[k*CH_W +: CH_W] = sharpen(rd_ctr[k*CH_W +: CH_W], rd_up[k*CH_W +: CH_W],
                                      s_px[k*CH_W +: CH_W], win_left[k*CH_W +: CH_W],
                                      rd_rgt[k*CH_W +: CH_W], strength);
      end
    end
  end

  assign push               = s_valid & (s_has_res | s_last_row);
  assign push_entry.res     = res;
  assign push_entry.px      = s_px;
  assign push_entry.has_res = s_has_res;
  assign push_entry.has_px  = s_last_row;
  assign push_entry.eof     = s_eof;

endmodule

// File: rtl/lsh_queue.sv
module lsh_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lsh_pkg::lsh_entry_t    push_entry,
  input  logic                   pop,
  output lsh_pkg::lsh_entry_t    head,
  output lsh_pkg::lsh_q_status_t q_stat
);
  import lsh_pkg::*;

  lsh_entry_t         mem [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      // push and pop together leave the count unchanged
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  assign head         = mem[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.empty = (count == '0);

endmodule

// File: rtl/lsh_back.sv
module lsh_back (
  input  logic                      clk,
  input  logic                      rst,
  input  lsh_pkg::lsh_entry_t       head,
  input  lsh_pkg::lsh_q_status_t    q_stat,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lsh_pkg::PIX_W-1:0] m_tdata,
  output logic                      m_tlast,
  output logic                      m_tuser
);
  import lsh_pkg::*;

  // phase set once the row-above result of a two-result entry has gone out
  logic phase;
  logic first_of_two, send_res, fire;

  assign first_of_two = head.has_res & head.has_px & ~phase;
  assign send_res     = head.has_res & ~phase;
  assign m_tvalid     = ~q_stat.empty;
  assign fire         = m_tvalid & m_tready;
  assign pop          = fire & ~first_of_two;

  always_comb begin
    if (send_res) begin
      m_tdata = head.res;
      m_tuser = ~head.has_px;
      m_tlast = 1'b0;
    end else begin
      m_tdata = head.px;
      m_tuser = 1'b1;
      m_tlast = head.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (fire) begin
      phase <= first_of_two;
    end
  end

endmodule
